FILE: hw/rtl/slm_pkg.sv
// ----------------------------------------------------------------------------
// slm_pkg
// Shared types and codes for the set membership lookup block.
// ----------------------------------------------------------------------------
package slm_pkg;

    localparam int unsigned FUNC_W  = 2;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned POS_W   = 31;
    localparam int unsigned OUT_W   = 40;

    localparam logic [FUNC_W-1:0]  FUNC_CLEAR = 2'd0;
    localparam logic [FUNC_W-1:0]  FUNC_LOAD  = 2'd1;
    localparam logic [FUNC_W-1:0]  FUNC_QUERY = 2'd2;

    localparam logic [VALUE_W-1:0] MISSING_CODE = 32'h8000_0000;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic clear;
        logic load;
        logic query_start;
        logic scan_issue;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic rd_pending;
        logic want_result;
        logic out_free;
        logic mode;
    } t_status;

endpackage

FILE: hw/rtl/slm_datapath.sv
// ----------------------------------------------------------------------------
// slm_datapath
// Entry memory, counters, sequential compare scan and output register.
// ----------------------------------------------------------------------------
module slm_datapath #(
    parameter int unsigned TABLE_DEPTH = 256
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  slm_pkg::t_cmd           i_cmd,
    output slm_pkg::t_status        o_status,
    input  logic [31:0]             i_value,
    input  logic                    i_cfg_we,
    input  logic                    i_cfg_data,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [39:0]             o_out_data
);
    import slm_pkg::*;

    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [VALUE_W-1:0] r_mem [TABLE_DEPTH];
    logic [VALUE_W-1:0] r_rd_data;
    logic               r_rd_vld;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_idx;
    logic [VALUE_W-1:0] r_qval;
    logic [POS_W-1:0]   r_qpos;
    logic               r_ovf;
    logic               r_hit;
    logic               r_mode;
    logic               r_out_vld;
    logic               r_out_found;
    logic [POS_W-1:0]   r_out_pos;
    logic               r_out_ovf;
    logic               w_full;

    assign w_full = (r_count >= CW'(TABLE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && !w_full) begin
            r_mem[r_count[AW-1:0]] <= i_value;
        end
        r_rd_data <= r_mem[r_idx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_idx     <= '0;
            r_qpos    <= '0;
            r_ovf     <= 1'b0;
            r_hit     <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_mode    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_data;
            end
            r_rd_vld <= i_cmd.scan_issue;
            if (i_cmd.clear) begin
                r_count <= '0;
                r_qpos  <= '0;
                r_ovf   <= 1'b0;
            end
            if (i_cmd.load) begin
                if (w_full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_count <= r_count + 1'b1;
                end
            end
            if (i_cmd.query_start) begin
                r_idx <= '0;
                r_hit <= 1'b0;
                if (r_qpos != '1) begin
                    r_qpos <= r_qpos + 1'b1;
                end
            end else begin
                if (i_cmd.scan_issue) begin
                    r_idx <= r_idx + 1'b1;
                end
                if (r_rd_vld && (r_rd_data == r_qval)) begin
                    r_hit <= 1'b1;
                end
            end
            if (i_cmd.emit) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.query_start) begin
            r_qval <= i_value;
        end
        if (i_cmd.emit) begin
            r_out_found <= r_hit;
            r_out_pos   <= r_qpos;
            r_out_ovf   <= r_ovf;
        end
    end

    always_comb begin
        o_status.scan_done   = (r_idx >= r_count);
        o_status.rd_pending  = r_rd_vld;
        o_status.want_result = !r_mode || (r_hit && (r_qval != MISSING_CODE));
        o_status.out_free    = !r_out_vld || i_out_ready;
        o_status.mode        = r_mode;
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = {7'b0, r_out_ovf, r_out_pos, r_out_found};

endmodule

FILE: hw/rtl/slm_ctrl.sv
// ----------------------------------------------------------------------------
// slm_ctrl
// Sequencer: decodes commands, steps the table scan, hands off results.
// ----------------------------------------------------------------------------
module slm_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic [1:0]          i_func,
    output logic                o_in_ready,
    input  slm_pkg::t_status    i_status,
    output slm_pkg::t_cmd       o_cmd
);
    import slm_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign w_accept = i_in_valid && (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && (i_func == FUNC_QUERY)) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_status.scan_done && !i_status.rd_pending) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!i_status.want_result || i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready        = 1'b1;
                o_cmd.clear       = w_accept && (i_func == FUNC_CLEAR);
                o_cmd.load        = w_accept && (i_func == FUNC_LOAD);
                o_cmd.query_start = w_accept && (i_func == FUNC_QUERY);
            end
            ST_SCAN: begin
                o_cmd.scan_issue = !i_status.scan_done;
            end
            ST_EMIT: begin
                o_cmd.emit = i_status.want_result && i_status.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

FILE: hw/rtl/set_membership_lookup.sv
// Query word: the stored entries are scanned, then a result, if one is reported,
// goes to the result register once it is free, and then the next word is taken.
// A result waits in the output register while the next word is taken.
// Synchronous active-low reset empties the table, zeroes counters and flags,
// and selects per-query reporting; no clearing pass over the memory.
// ----------------------------------------------------------------------------
// set_membership_lookup
// Membership test of a query stream against a loaded table of 32-bit values.
// ----------------------------------------------------------------------------
module set_membership_lookup #(
    parameter int unsigned TABLE_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    input  logic [1:0]  s_axis_tuser,   // [1:0] func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [0] found, [31:1] query_position,
                                        // [32] table_overflow
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data      // report_matches_only
);
    import slm_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    assign o_cfg_ready = 1'b1;

    slm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_func     (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    slm_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_value     (s_axis_tdata),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

    a_match_only_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && w_status.mode) |-> m_axis_tdata[0])
        else $error("non-match reported in matches-only mode");

    a_pos_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[31:1] != '0))
        else $error("result with zero query position");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser == FUNC_QUERY))
        |=> !s_axis_tready)
        else $error("input ready during query scan");

    a_single_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.clear, w_cmd.load, w_cmd.query_start, w_cmd.scan_issue,
                  w_cmd.emit}))
        else $error("conflicting datapath commands");

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives clear, load and query words into set_membership_lookup and compares
// each result word with a scoreboard that tracks the table, the query
// position and the overflow flag. Both reporting modes are covered, with
// random idling on both sides and a long output hold-off.
// ----------------------------------------------------------------------------
module testbench;
    import slm_pkg::*;

    localparam int unsigned DEPTH       = 256;
    localparam int unsigned DRAIN_WAIT  = DEPTH + 40;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned CYCLE_LIMIT = 3_000_000;
    localparam int unsigned ITEM_TARGET = 1950;

    localparam logic [FUNC_W-1:0]  FUNC_UNUSED = 2'd3;
    localparam logic [VALUE_W-1:0] VALUE_MAX   = 32'h7FFF_FFFF;

    class membership_scoreboard;
        typedef struct packed {
            logic             found;
            logic [POS_W-1:0] position;
            logic             overflow;
        } t_lookup;

        logic [VALUE_W-1:0] entries [DEPTH];
        int unsigned        n_entries;
        logic [POS_W-1:0]   position;
        logic               overflow;
        logic               matches_only;
        t_lookup            awaited [$];
        int unsigned        errors;

        function new();
            n_entries    = 0;
            position     = '0;
            overflow     = 1'b0;
            matches_only = 1'b0;
            errors       = 0;
        endfunction

        function void set_mode(logic mode);
            matches_only = mode;
        endfunction

        function int unsigned pending();
            return awaited.size();
        endfunction

        // update table state for an accepted word; queue the result it causes
        function void note_word(logic [FUNC_W-1:0] func, logic [VALUE_W-1:0] value);
            t_lookup r;
            logic    hit;
            case (func)
                FUNC_CLEAR: begin
                    n_entries = 0;
                    position  = '0;
                    overflow  = 1'b0;
                end
                FUNC_LOAD: begin
                    if (n_entries < DEPTH) begin
                        entries[n_entries] = value;
                        n_entries++;
                    end else begin
                        overflow = 1'b1;
                    end
                end
                FUNC_QUERY: begin
                    if (position != '1)
                        position++;
                    hit = 1'b0;
                    for (int unsigned i = 0; i < n_entries; i++)
                        if (entries[i] == value)
                            hit = 1'b1;
                    if (!(matches_only && (value == MISSING_CODE || !hit))) begin
                        r.found    = hit;
                        r.position = position;
                        r.overflow = overflow;
                        awaited = {awaited, r};
                    end
                end
                default: ;
            endcase
        endfunction

        task report_mismatch(string msg);
            $display("%0t mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(logic [OUT_W-1:0] word);
            t_lookup want;
            if (awaited.size() == 0) begin
                report_mismatch($sformatf("result word %h with none expected", word));
                return;
            end
            want = awaited.pop_front();
            if (word[0] !== want.found)
                report_mismatch($sformatf("found %b, want %b", word[0], want.found));
            if (word[POS_W:1] !== want.position)
                report_mismatch($sformatf("position %0d, want %0d",
                                          word[POS_W:1], want.position));
            if (word[POS_W+1] !== want.overflow)
                report_mismatch($sformatf("overflow %b, want %b",
                                          word[POS_W+1], want.overflow));
        endtask
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [VALUE_W-1:0]   s_axis_tdata;   // [31:0] value
    logic [FUNC_W-1:0]    s_axis_tuser;   // [1:0] func
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [OUT_W-1:0]     m_axis_tdata;   // [0] found, [31:1] query_position,
                                          // [32] table_overflow
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic                 i_cfg_data;     // report_matches_only

    membership_scoreboard sb;
    int unsigned          snd_idle_pct;
    int unsigned          rcv_idle_pct;
    bit                   hold_req;
    int unsigned          n_items;
    int unsigned          cycles;

    set_membership_lookup #(
        .TABLE_DEPTH(DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_word(s_axis_tuser, s_axis_tdata);
            if (i_cfg_valid && o_cfg_ready)
                sb.set_mode(i_cfg_data);
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
            end
        end
    end

    task automatic send_word(input logic [FUNC_W-1:0] func, input logic [VALUE_W-1:0] value);
        while ($urandom_range(99) < snd_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= value;
        do @(posedge i_clk); while (!s_axis_tready);
        if (func != FUNC_UNUSED)
            n_items++;
    endtask

    // wait for every expected word, then for a scan that yields nothing
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic mode);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= mode;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(9))
            0:       return MISSING_CODE;
            1:       return VALUE_MAX;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // optional clear, n_load entries, then a mix of queries with some noise
    task automatic run_set(input int unsigned n_load, input int unsigned n_query,
                           input bit do_clear);
        logic [VALUE_W-1:0] stored [$];
        logic [VALUE_W-1:0] v;
        int unsigned        r;
        if (do_clear)
            send_word(FUNC_CLEAR, $urandom);
        repeat (n_load) begin
            v = pick_value();
            stored = {stored, v};
            send_word(FUNC_LOAD, v);
        end
        repeat (n_query) begin
            r = $urandom_range(99);
            if (r < 45 && stored.size() != 0) begin
                send_word(FUNC_QUERY, stored[$urandom_range(stored.size() - 1)]);
            end else if (r < 55) begin
                send_word(FUNC_QUERY, MISSING_CODE);
            end else if (r < 60) begin
                send_word(FUNC_UNUSED, $urandom);
            end else if (r < 66) begin
                v = pick_value();
                stored = {stored, v};
                send_word(FUNC_LOAD, v);
            end else if (r < 68) begin
                stored.delete();
                send_word(FUNC_CLEAR, $urandom);
            end else begin
                send_word(FUNC_QUERY, $urandom);
            end
        end
    endtask

    initial begin
        int unsigned round_no;
        bit          held;
        sb = new();
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= FUNC_CLEAR;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= 1'b0;
        hold_req      = 1'b0;
        snd_idle_pct  = 0;
        rcv_idle_pct  = 0;
        n_items       = 0;
        round_no      = 0;
        held          = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // per-query mode from reset; empty table first
        send_word(FUNC_QUERY, '0);
        send_word(FUNC_LOAD, VALUE_MAX);
        send_word(FUNC_LOAD, MISSING_CODE);
        send_word(FUNC_LOAD, '0);
        send_word(FUNC_LOAD, '1);
        send_word(FUNC_LOAD, 32'd1);
        send_word(FUNC_QUERY, VALUE_MAX);
        send_word(FUNC_QUERY, MISSING_CODE);
        send_word(FUNC_QUERY, '1);
        send_word(FUNC_QUERY, 32'd2);
        send_word(FUNC_QUERY, 32'hFFFF_FFFE);
        send_word(FUNC_UNUSED, '1);
        send_word(FUNC_QUERY, 32'd1);
        send_word(FUNC_CLEAR, '1);
        send_word(FUNC_QUERY, '0);

        // matches-only: a query for the missing code is never reported
        write_mode(1'b1);
        send_word(FUNC_LOAD, MISSING_CODE);
        send_word(FUNC_LOAD, 32'd5);
        send_word(FUNC_QUERY, MISSING_CODE);
        send_word(FUNC_QUERY, 32'd5);
        send_word(FUNC_QUERY, 32'd6);

        for (int ph = 0; ph < 3; ph++) begin
            snd_idle_pct = (ph == 0) ? 27 : (ph == 1) ? 61 : 0;
            rcv_idle_pct = (ph == 0) ? 61 : (ph == 1) ? 27 : 0;
            while (n_items < ITEM_TARGET * (ph + 1) / 3) begin
                write_mode(($urandom_range(3) == 0) ? 1'($urandom_range(1)) : round_no[0]);
                if (ph == 2 && !held) begin
                    hold_req = 1'b1;
                    held     = 1'b1;
                    run_set(4, 40, 1'b1);
                end else if (round_no % 20 == 7) begin
                    run_set(DEPTH + $urandom_range(6), 10, 1'b1);
                end else begin
                    run_set($urandom_range(12), $urandom_range(8, 30),
                            (sb.n_entries > 40) || ($urandom_range(99) < 85));
                end
                round_no++;
            end
        end

        drain();
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/slm_pkg.sv
hw/rtl/slm_datapath.sv
hw/rtl/slm_ctrl.sv
hw/rtl/set_membership_lookup.sv
sim/testbench.sv
